// ----- design/plasma_pixel_generator_assert.svh -----
// assertion macros used by the plasma pixel generator rtl
`ifndef PLASMA_PIXEL_GENERATOR_ASSERT_SVH
`define PLASMA_PIXEL_GENERATOR_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define PPG_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define PPG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/ppg_pkg.sv -----
// types, constants and phase helpers of the plasma pixel generator
`default_nettype none

package ppg_pkg;

	// phase words: 2^25 per turn, kept modulo 2^26 (half index reads bit 25)
	localparam int PH_W = 26;
	localparam int IDX_W = 12;
	localparam int SIN_W = 14;
	localparam int COORD_W = 11;
	localparam int CXY_W = 25;
	localparam int SQ_W = 48;
	localparam int R_W = 58;
	localparam int ROOT_W = 29;
	localparam int REM_W = ROOT_W + 2;
	localparam int SIN_LAT = 5;

	// time steps per frame
	localparam logic [18:0] T_STEP = 19'd267018;
	localparam logic [15:0] T5_STEP = 16'd53403;
	localparam logic [16:0] T3_STEP = 17'd89006;
	localparam logic [17:0] DIV5_RECIP = 18'd209716;

	// coordinate scales and root to phase factor
	localparam int XY_STEP = 80105;
	localparam int CXY_STEP = 1573;
	localparam logic [18:0] ROOT_TO_PHASE = 19'd333772;

	typedef logic [PH_W-1:0] phase_t;
	typedef logic [IDX_W-1:0] phase_idx_t;
	typedef logic signed [SIN_W-1:0] sin_q12_t;

	typedef enum logic [0:0] {
		CFG_FRAME = 1'b0,
		CFG_BRIGHT = 1'b1
	} cfg_index_t;

	typedef struct packed {
		sin_q12_t s_x;
		sin_q12_t s_y;
		sin_q12_t s_xy;
	} sin3_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pix_t;

	// table entry for a full angle
	function automatic phase_idx_t full_index(input phase_t a);
		phase_t s;
		s = a + PH_W'(4096);
		return s[24:13];
	endfunction

	// table entry for a halved angle
	function automatic phase_idx_t half_index(input phase_t a);
		phase_t s;
		s = a + PH_W'(8192);
		return s[25:14];
	endfunction

endpackage

`default_nettype wire

// ----- design/ppg_sine.sv -----
// five stage pipelined q12 sine from a 12-bit phase index
`default_nettype none

module ppg_sine import ppg_pkg::*; (
	input logic clk,
	input logic en,
	input phase_idx_t idx,
	output sin_q12_t sin_q12
);

	logic [1:0] quad_s1, quad_s2, quad_s3, quad_s4;
	logic [16:0] z_s1, z_s2, z_s3, z_s4;
	logic [16:0] z2_s1, z2_s2, z2_s3;
	logic [12:0] t1_s2;
	logic [15:0] t2_s3;
	logic [16:0] t3_s4;
	sin_q12_t sin_s5;

	logic [10:0] q;
	logic [16:0] z;
	logic [33:0] zz;
	logic [28:0] p2;
	logic [31:0] p3;
	logic [32:0] p4;
	logic [33:0] p5;
	logic [18:0] s8;
	logic [14:0] s12;
	logic [12:0] mag;

	// fold to the first quadrant and square
	always_comb begin
		q = idx[10] ? (11'd1024 - {1'b0, idx[9:0]}) : {1'b0, idx[9:0]};
		z = {q, 6'd0};
		zz = {17'd0, z} * {17'd0, z};
	end

	// polynomial steps, one product per stage
	always_comb begin
		p2 = {12'd0, z2_s1} * 29'd307;
		p3 = {15'd0, z2_s2} * {19'd0, t1_s2};
		p4 = {16'd0, z2_s3} * {17'd0, t2_s3};
		p5 = {17'd0, z_s4} * {17'd0, t3_s4};
		s8 = {1'b0, p5[33:16]} + 19'd8;
		s12 = s8[18:4];
		mag = (s12 > 15'd4096) ? 13'd4096 : s12[12:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quad_s1 <= idx[11:10];
			z_s1 <= z;
			z2_s1 <= zz[32:16];
			quad_s2 <= quad_s1;
			z_s2 <= z_s1;
			z2_s2 <= z2_s1;
			t1_s2 <= 13'd5223 - p2[28:16];
			quad_s3 <= quad_s2;
			z_s3 <= z_s2;
			z2_s3 <= z2_s2;
			t2_s3 <= 16'd42334 - p3[31:16];
			quad_s4 <= quad_s3;
			z_s4 <= z_s3;
			t3_s4 <= 17'd102944 - p4[32:16];
			sin_s5 <= quad_s4[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
		end
	end

	assign sin_q12 = sin_s5;

endmodule

`default_nettype wire

// ----- design/ppg_isqrt.sv -----
// pipelined floor square root, one result bit per stage
`default_nettype none

module ppg_isqrt import ppg_pkg::*; (
	input logic clk,
	input logic en,
	input logic [R_W-1:0] radicand,
	output logic [ROOT_W-1:0] root
);

	logic [R_W-1:0] rad_s [ROOT_W];
	logic [REM_W-1:0] rem_s [ROOT_W];
	logic [ROOT_W-1:0] root_s [ROOT_W];

	for (genvar k = 0; k < ROOT_W; k++) begin : g_step
		logic [R_W-1:0] rad_p;
		logic [REM_W-1:0] rem_p;
		logic [ROOT_W-1:0] root_p;
		logic [REM_W+1:0] cand;
		logic [REM_W+1:0] trial;

		// previous stage, or the radicand at the head
		if (k == 0) begin : g_head
			assign rad_p = radicand;
			assign rem_p = '0;
			assign root_p = '0;
		end else begin : g_body
			assign rad_p = rad_s[k-1];
			assign rem_p = rem_s[k-1];
			assign root_p = root_s[k-1];
		end

		// bring down two bits and try the next root bit
		assign cand = {rem_p, rad_p[R_W-1:R_W-2]};
		assign trial = {2'b00, root_p, 2'b01};

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[k] <= {rad_p[R_W-3:0], 2'b00};
				if (cand >= trial) begin
					rem_s[k] <= REM_W'(cand - trial);
					root_s[k] <= {root_p[ROOT_W-2:0], 1'b1};
				end else begin
					rem_s[k] <= cand[REM_W-1:0];
					root_s[k] <= {root_p[ROOT_W-2:0], 1'b0};
				end
			end
		end
	end

	assign root = root_s[ROOT_W-1];

endmodule

`default_nettype wire

// ----- design/ppg_frame.sv -----
// frame time phases and the moving centre sines, free running from the frame register
`default_nettype none

module ppg_frame import ppg_pkg::*; (
	input logic clk,
	input logic [15:0] frame_number,
	output phase_t t_phase,
	output sin_q12_t sin_t5,
	output sin_q12_t cos_t3
);

	phase_t t_s1, t5m_s1, t3_s1;
	logic [15:0] q5_s1;
	phase_idx_t idx5_s2, idx3_s2;

	logic [34:0] pt;
	logic [31:0] pt5;
	logic [32:0] pt3;
	logic [17:0] f3;
	logic [35:0] pq;

	// t, t/5 and t/3 as phases; t/5 = f*53403 + floor(3f/5)
	always_comb begin
		pt = {19'd0, frame_number} * {16'd0, T_STEP};
		pt5 = {16'd0, frame_number} * {16'd0, T5_STEP};
		pt3 = {17'd0, frame_number} * {16'd0, T3_STEP};
		f3 = {1'b0, frame_number, 1'b0} + {2'b00, frame_number};
		pq = {18'd0, f3} * {18'd0, DIV5_RECIP};
	end

	always_ff @(posedge clk) begin
		t_s1 <= pt[PH_W-1:0];
		t5m_s1 <= pt5[PH_W-1:0];
		t3_s1 <= pt3[PH_W-1:0];
		q5_s1 <= pq[35:20];
		idx5_s2 <= full_index(t5m_s1 + {10'd0, q5_s1});
		idx3_s2 <= full_index(t3_s1) + IDX_W'(1024);
	end

	ppg_sine u_sin_t5 (
		.clk(clk),
		.en(1'b1),
		.idx(idx5_s2),
		.sin_q12(sin_t5)
	);

	ppg_sine u_cos_t3 (
		.clk(clk),
		.en(1'b1),
		.idx(idx3_s2),
		.sin_q12(cos_t3)
	);

	assign t_phase = t_s1;

endmodule

`default_nettype wire

// ----- design/plasma_pixel_generator.sv -----
// plasma pixel generator: 53 stage pipeline with an output register and skid stage
// throughput: one pixel per cycle while the skid stage is empty
// the square root takes one stage per root bit
// a stalled output fills the skid stage first, then the pipeline holds
// reset clears valid bits and output flags; frame_number to 0, brightness_level to 64
`default_nettype none
`include "plasma_pixel_generator_assert.svh"

module plasma_pixel_generator import ppg_pkg::*; #(
	parameter int SURFACE_WIDTH = 320,
	parameter int SURFACE_HEIGHT = 240,
	parameter int UPSCALE = 4
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_write,
	input logic [0:0] cfg_index,
	input logic [15:0] cfg_data,
	input logic in_valid,
	output logic in_ready,
	input logic [8:0] pixel_x,
	input logic [7:0] pixel_y,
	output logic out_valid,
	input logic out_ready,
	output logic [7:0] red_value,
	output logic [7:0] green_value,
	output logic [7:0] blue_value
);

	localparam logic signed [COORD_W-1:0] HALF_W = COORD_W'(SURFACE_WIDTH / 2);
	localparam logic signed [COORD_W-1:0] HALF_H = COORD_W'(SURFACE_HEIGHT / 2);
	localparam logic signed [22:0] XY_K = 23'(UPSCALE * XY_STEP);
	localparam logic signed [15:0] CXY_K = 16'(UPSCALE * CXY_STEP);
	localparam int CXY_DLY = 4;
	localparam int SIN3_DLY = ROOT_W + SIN_LAT + 5;
	localparam int PIPE_DEPTH = ROOT_W + 2 * SIN_LAT + 14;

	logic [15:0] frame_q;
	logic [7:0] bright_q;
	logic en;
	logic [PIPE_DEPTH-1:0] valid_s;

	phase_t t_phase;
	sin_q12_t sin_t5, cos_t3;

	logic signed [COORD_W-1:0] dx_s1, dy_s1;
	phase_t xu_s2, yu_s2;
	logic signed [CXY_W-1:0] cxb_s2, cyb_s2, cxb_s3, cyb_s3;
	phase_idx_t idx_x_s3, idx_y_s3, idx_xy_s3;
	logic signed [CXY_W-1:0] cxb_dly_s [CXY_DLY];
	logic signed [CXY_W-1:0] cyb_dly_s [CXY_DLY];
	logic signed [CXY_W-1:0] cx_s8, cy_s8;
	logic [SQ_W-1:0] sqx_s9, sqy_s9;
	logic [SQ_W:0] sq_s10;
	logic [R_W-1:0] r_s11;
	logic [ROOT_W-1:0] root_s40;
	phase_t ru_s41;
	phase_idx_t idx_r_s42;
	sin3_t sin3_dly_s [SIN3_DLY];
	phase_idx_t pidx_s48, cidx_s48;

	sin3_t sin3_s8;
	sin_q12_t sin_r_s47, sv_s53, cv_s53;

	logic signed [32:0] xu_p, yu_p;
	logic signed [26:0] cxb_p, cyb_p;
	logic signed [49:0] sqx_p, sqy_p;
	logic [47:0] ru_p;
	logic signed [15:0] sum_n;
	pix_t pix_n;

	pix_t out_q, skid_q;
	logic out_v_q, skid_v_q;
	logic pop, push;

	// red or green from a q12 sine and the brightness
	function automatic logic [7:0] chan(input logic [7:0] b, input sin_q12_t s);
		logic [13:0] a;
		logic [22:0] m;
		logic signed [8:0] bm;
		logic signed [24:0] n;
		a = 14'($signed({s[SIN_W-1], s}) + 15'sd4096);
		m = {14'd0, b, 1'b0} * {9'd0, a};
		bm = $signed({1'b0, b}) - 9'sd64;
		n = $signed({2'b00, m}) + 25'($signed({bm, 12'd0}));
		if (n <= 25'sd0) begin
			return 8'd0;
		end else if (n[24:12] > 13'd255) begin
			return 8'd255;
		end else begin
			return n[19:12];
		end
	endfunction

	// blue depends on the brightness only
	function automatic logic [7:0] blue_of(input logic [7:0] b);
		logic signed [10:0] v;
		v = $signed({1'b0, b, 2'b00}) - 11'sd255;
		if (v < 11'sd0) begin
			return 8'd0;
		end else if (v > 11'sd255) begin
			return 8'd255;
		end else begin
			return v[7:0];
		end
	endfunction

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q <= 16'd0;
			bright_q <= 8'd64;
		end else if (cfg_write) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_FRAME: frame_q <= cfg_data;
				CFG_BRIGHT: bright_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	ppg_frame u_frame (
		.clk(clk),
		.frame_number(frame_q),
		.t_phase(t_phase),
		.sin_t5(sin_t5),
		.cos_t3(cos_t3)
	);

	// pipeline advances unless the skid stage holds a transaction
	assign en = !skid_v_q;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else if (en) begin
			valid_s <= {valid_s[PIPE_DEPTH-2:0], in_valid};
		end
	end

	// coordinate products
	always_comb begin
		xu_p = 33'(dx_s1) * 33'(XY_K);
		yu_p = 33'(dy_s1) * 33'(XY_K);
		cxb_p = 27'(dx_s1) * 27'(CXY_K);
		cyb_p = 27'(dy_s1) * 27'(CXY_K);
	end

	// centre, scale and index the three coordinate sines
	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1 <= $signed({2'b00, pixel_x}) - HALF_W;
			dy_s1 <= $signed({3'b000, pixel_y}) - HALF_H;
			xu_s2 <= xu_p[PH_W-1:0];
			yu_s2 <= yu_p[PH_W-1:0];
			cxb_s2 <= cxb_p[CXY_W-1:0];
			cyb_s2 <= cyb_p[CXY_W-1:0];
			idx_x_s3 <= full_index(xu_s2 + t_phase);
			idx_y_s3 <= half_index(yu_s2 + t_phase);
			idx_xy_s3 <= half_index(xu_s2 + yu_s2 + t_phase);
			cxb_s3 <= cxb_s2;
			cyb_s3 <= cyb_s2;
		end
	end

	ppg_sine u_sin_x (.clk(clk), .en(en), .idx(idx_x_s3), .sin_q12(sin3_s8.s_x));
	ppg_sine u_sin_y (.clk(clk), .en(en), .idx(idx_y_s3), .sin_q12(sin3_s8.s_y));
	ppg_sine u_sin_xy (.clk(clk), .en(en), .idx(idx_xy_s3), .sin_q12(sin3_s8.s_xy));

	// centre offsets wait for the moving centre sines
	always_ff @(posedge clk) begin
		if (en) begin
			cxb_dly_s[0] <= cxb_s3;
			cyb_dly_s[0] <= cyb_s3;
			for (int i = 1; i < CXY_DLY; i++) begin
				cxb_dly_s[i] <= cxb_dly_s[i-1];
				cyb_dly_s[i] <= cyb_dly_s[i-1];
			end
		end
	end

	// squares and the radial argument in q40
	always_comb begin
		sqx_p = 50'(cx_s8) * 50'(cx_s8);
		sqy_p = 50'(cy_s8) * 50'(cy_s8);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cx_s8 <= cxb_dly_s[CXY_DLY-1] + $signed({{4{sin_t5[SIN_W-1]}}, sin_t5, 7'd0});
			cy_s8 <= cyb_dly_s[CXY_DLY-1] + $signed({{4{cos_t3[SIN_W-1]}}, cos_t3, 7'd0});
			sqx_s9 <= sqx_p[SQ_W-1:0];
			sqy_s9 <= sqy_p[SQ_W-1:0];
			sq_s10 <= {1'b0, sqx_s9} + {1'b0, sqy_s9};
			r_s11 <= ({9'd0, sq_s10} << 6) + ({9'd0, sq_s10} << 5) + ({9'd0, sq_s10} << 2)
				+ (R_W'(1) << 40);
		end
	end

	ppg_isqrt u_isqrt (
		.clk(clk),
		.en(en),
		.radicand(r_s11),
		.root(root_s40)
	);

	// root in q20 radians to phase, then the radial sine
	assign ru_p = {19'd0, root_s40} * {29'd0, ROOT_TO_PHASE};

	always_ff @(posedge clk) begin
		if (en) begin
			ru_s41 <= ru_p[PH_W+15:16];
			idx_r_s42 <= full_index(ru_s41 + t_phase);
		end
	end

	ppg_sine u_sin_r (.clk(clk), .en(en), .idx(idx_r_s42), .sin_q12(sin_r_s47));

	// coordinate sines wait for the radial one
	always_ff @(posedge clk) begin
		if (en) begin
			sin3_dly_s[0] <= sin3_s8;
			for (int i = 1; i < SIN3_DLY; i++) begin
				sin3_dly_s[i] <= sin3_dly_s[i-1];
			end
		end
	end

	// sum of four sines gives the pi*v phase
	assign sum_n = 16'(sin3_dly_s[SIN3_DLY-1].s_x) + 16'(sin3_dly_s[SIN3_DLY-1].s_y)
		+ 16'(sin3_dly_s[SIN3_DLY-1].s_xy) + 16'(sin_r_s47) + 16'sd2;

	always_ff @(posedge clk) begin
		if (en) begin
			pidx_s48 <= sum_n[13:2];
			cidx_s48 <= sum_n[13:2] + IDX_W'(1024);
		end
	end

	ppg_sine u_sin_v (.clk(clk), .en(en), .idx(pidx_s48), .sin_q12(sv_s53));
	ppg_sine u_cos_v (.clk(clk), .en(en), .idx(cidx_s48), .sin_q12(cv_s53));

	// colour channels
	always_comb begin
		pix_n.red = chan(bright_q, sv_s53);
		pix_n.green = chan(bright_q, cv_s53);
		pix_n.blue = blue_of(bright_q);
	end

	// output register with skid stage
	assign pop = out_v_q && out_ready;
	assign push = en && valid_s[PIPE_DEPTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (pop) begin
				skid_v_q <= 1'b0;
			end
		end else if (push) begin
			if (out_v_q && !pop) begin
				skid_v_q <= 1'b1;
			end else begin
				out_v_q <= 1'b1;
			end
		end else if (pop) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (pop) begin
				out_q <= skid_q;
			end
		end else if (push) begin
			if (out_v_q && !pop) begin
				skid_q <= pix_n;
			end else begin
				out_q <= pix_n;
			end
		end
	end

	assign out_valid = out_v_q;
	assign red_value = out_q.red;
	assign green_value = out_q.green;
	assign blue_value = out_q.blue;

	`PPG_ASSERT_SAME(a_skid_behind_out, clk, arst_n, skid_v_q, out_v_q, "skid full with output empty")
	`PPG_ASSERT_NEXT(a_no_drop, clk, arst_n, valid_s[PIPE_DEPTH-1] && !skid_v_q, out_v_q, "pixel lost at output")
	`PPG_ASSERT_SAME(a_skid_on_stall, clk, arst_n, $rose(skid_v_q), $past(out_v_q && !out_ready), "skid filled without stall")

endmodule

`default_nettype wire

// ----- test/plasma_pixel_checker.sv -----
// checker for the plasma pixel generator: predicts each pixel colour and compares
`timescale 1ns / 1ps

module plasma_pixel_checker import ppg_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_write,
	input logic [0:0] cfg_index,
	input logic [15:0] cfg_data,
	input logic in_valid,
	input logic in_ready,
	input logic [8:0] pixel_x,
	input logic [7:0] pixel_y,
	input logic out_valid,
	input logic out_ready,
	input logic [7:0] red_value,
	input logic [7:0] green_value,
	input logic [7:0] blue_value,
	output int fail_count,
	output int pending
);

	localparam int SURF_W = 320;
	localparam int SURF_H = 240;
	localparam int UPSC = 4;
	localparam longint unsigned TIME_STEP = 267018;
	localparam longint unsigned PIX_STEP = 80105;
	localparam longint signed CENTRE_STEP = 1573;
	localparam longint unsigned RAD_TO_PHASE = 333772;

	logic [15:0] frame_q;
	logic [7:0] bright_q;
	pix_t colour_queue[$];

	assign pending = colour_queue.size();

	// quarter-wave polynomial sine, Q12 out, 4096 entries per turn
	function automatic int sine_lut(input logic [11:0] idx);
		logic [1:0] quad;
		longint unsigned q, z, z2, t, s, s12;
		quad = idx[11:10];
		q = quad[0] ? (1024 - idx[9:0]) : idx[9:0];
		z = q << 6;
		z2 = (z * z) >> 16;
		t = 5223 - ((z2 * 307) >> 16);
		t = 42334 - ((z2 * t) >> 16);
		t = 102944 - ((z2 * t) >> 16);
		s = (z * t) >> 16;
		s12 = (s + 8) >> 4;
		if (s12 > 4096)
			s12 = 4096;
		return quad[1] ? -int'(s12) : int'(s12);
	endfunction

	function automatic logic [11:0] whole_angle_idx(input logic [31:0] a);
		logic [31:0] s;
		s = a + 32'd4096;
		return s[24:13];
	endfunction

	function automatic logic [11:0] halved_angle_idx(input logic [31:0] a);
		logic [31:0] s;
		s = a + 32'd8192;
		return s[25:14];
	endfunction

	// floor integer square root, bit by bit
	function automatic longint unsigned floor_root(input longint unsigned n);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > n)
			bitv >>= 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	// brightness-weighted channel with saturation
	function automatic logic [7:0] shade(input longint b, input int s);
		longint n;
		n = 2 * b * (4096 + longint'(s)) + (b - 64) * 4096;
		if (n <= 0)
			return 8'd0;
		n = n / 4096;
		return (n > 255) ? 8'd255 : 8'(n);
	endfunction

	function automatic pix_t plasma_colour(input logic [8:0] px, input logic [7:0] py,
		input logic [15:0] frame, input logic [7:0] bright);
		longint dx, dy, cx, cy, b, blue;
		longint unsigned t_full, r, root;
		logic [31:0] tu, xu, yu, ru, sum_w;
		int st5, ct3, sum, sv, cv;
		logic [11:0] pidx;
		pix_t p;
		dx = longint'(px) - SURF_W / 2;
		dy = longint'(py) - SURF_H / 2;
		t_full = longint'(frame) * TIME_STEP;
		tu = t_full[31:0];
		xu = 32'(dx * longint'(UPSC * PIX_STEP));
		yu = 32'(dy * longint'(UPSC * PIX_STEP));
		st5 = sine_lut(whole_angle_idx(32'(t_full / 5)));
		ct3 = sine_lut(whole_angle_idx(32'(t_full / 3)) + 12'd1024);
		cx = dx * (UPSC * CENTRE_STEP) + longint'(st5) * 128;
		cy = dy * (UPSC * CENTRE_STEP) + longint'(ct3) * 128;
		r = longint'(cx * cx) + longint'(cy * cy);
		r = r * 100 + (64'd1 << 40);
		root = floor_root(r);
		ru = 32'((root * RAD_TO_PHASE) >> 16);
		sum = sine_lut(whole_angle_idx(xu + tu));
		sum += sine_lut(halved_angle_idx(yu + tu));
		sum += sine_lut(halved_angle_idx(xu + yu + tu));
		sum += sine_lut(whole_angle_idx(ru + tu));
		sum_w = 32'(sum + 2);
		pidx = sum_w[13:2];
		sv = sine_lut(pidx);
		cv = sine_lut(pidx + 12'd1024);
		b = longint'(bright);
		blue = 4 * b - 255;
		p.red = shade(b, sv);
		p.green = shade(b, cv);
		p.blue = (blue < 0) ? 8'd0 : ((blue > 255) ? 8'd255 : 8'(blue));
		return p;
	endfunction

	// register shadow, prediction on input transactions, compare on output transactions
	always @(posedge clk or negedge arst_n) begin
		pix_t want;
		int errs;
		errs = 0;
		if (!arst_n) begin
			frame_q <= 16'd0;
			bright_q <= 8'd64;
			fail_count <= 0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					CFG_FRAME: frame_q <= cfg_data;
					CFG_BRIGHT: bright_q <= cfg_data[7:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				colour_queue.push_back(plasma_colour(pixel_x, pixel_y, frame_q, bright_q));
			if (out_valid && out_ready) begin
				if (colour_queue.size() == 0) begin
					$display("%0t: unexpected pixel r=%0d g=%0d b=%0d", $time,
						red_value, green_value, blue_value);
					errs = errs + 1;
				end else begin
					want = colour_queue.pop_front();
					if (want.red !== red_value) begin
						$display("%0t: red expected %0d actual %0d", $time, want.red, red_value);
						errs = errs + 1;
					end
					if (want.green !== green_value) begin
						$display("%0t: green expected %0d actual %0d", $time, want.green,
							green_value);
						errs = errs + 1;
					end
					if (want.blue !== blue_value) begin
						$display("%0t: blue expected %0d actual %0d", $time, want.blue,
							blue_value);
						errs = errs + 1;
					end
				end
			end
			fail_count <= fail_count + errs;
		end
	end

endmodule

// ----- test/testbench.sv -----
// stimulus and verdict for the plasma pixel generator
`timescale 1ns / 1ps

module testbench import ppg_pkg::*;;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_CYCLES = 100;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write = 1'b0;
	logic [0:0] cfg_index = CFG_FRAME;
	logic [15:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [8:0] pixel_x = '0;
	logic [7:0] pixel_y = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [7:0] red_value, green_value, blue_value;
	int fail_count, pending;
	int cycle_count = 0;
	int stall_left = 0;
	bit calm_sender = 1'b0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	plasma_pixel_generator DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .pixel_x(pixel_x), .pixel_y(pixel_y),
		.out_valid(out_valid), .out_ready(out_ready),
		.red_value(red_value), .green_value(green_value), .blue_value(blue_value)
	);

	plasma_pixel_checker colour_check (
		.clk(clk), .arst_n(arst_n),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .pixel_x(pixel_x), .pixel_y(pixel_y),
		.out_valid(out_valid), .out_ready(out_ready),
		.red_value(red_value), .green_value(green_value), .blue_value(blue_value),
		.fail_count(fail_count), .pending(pending)
	);

	// mostly short gaps, a few long ones
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 19);
		if (r < 12)
			return 0;
		if (r < 18)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// cycle limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// receiver stalls, with quiet stretches
	always @(posedge clk) begin
		if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			out_ready <= 1'b1;
			if ((cycle_count / 500) % 4 != 3)
				stall_left <= gap_len();
		end
	end

	task automatic send_pixel(input logic [8:0] x, input logic [7:0] y);
		int gap;
		gap = calm_sender ? 0 : gap_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		pixel_x <= x;
		pixel_y <= y;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// register writes only once the pipeline has drained
	task automatic set_registers(input logic [15:0] frame, input logic [7:0] bright);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= CFG_FRAME;
		cfg_data <= frame;
		@(posedge clk);
		cfg_index <= CFG_BRIGHT;
		cfg_data <= {8'($urandom_range(0, 255)), bright};
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic random_pixels(input int count);
		for (int i = 0; i < count; i++) begin
			calm_sender = (i / 40) % 3 == 2;
			if ($urandom_range(0, 9) == 0)
				send_pixel(9'($urandom_range(0, 511)), 8'($urandom_range(0, 255)));
			else
				send_pixel(9'($urandom_range(0, 319)), 8'($urandom_range(0, 239)));
		end
		calm_sender = 1'b0;
	endtask

	initial begin
		logic [15:0] frames[9];
		logic [7:0] brights[9];
		frames = '{16'd0, 16'd65535, 16'd0, 16'd1, 16'd32768, 16'd65534, 16'd0, 16'd0, 16'd0};
		brights = '{8'd64, 8'd255, 8'd0, 8'd16, 8'd63, 8'd128, 8'd0, 8'd0, 8'd0};
		for (int k = 6; k < 9; k++) begin
			frames[k] = 16'($urandom_range(0, 65535));
			brights[k] = 8'($urandom_range(0, 255));
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset registers, corners, centre, off-surface extremes
		send_pixel(9'd0, 8'd0);
		send_pixel(9'd319, 8'd239);
		send_pixel(9'd160, 8'd120);
		send_pixel(9'd0, 8'd239);
		send_pixel(9'd319, 8'd0);
		send_pixel(9'd511, 8'd255);
		send_pixel(9'd320, 8'd240);
		send_pixel(9'd256, 8'd128);
		send_pixel(9'd255, 8'd127);
		send_pixel(9'd1, 8'd1);
		set_registers(16'd65535, 8'd255);
		send_pixel(9'd0, 8'd0);
		send_pixel(9'd511, 8'd255);
		send_pixel(9'd160, 8'd120);
		set_registers(16'd0, 8'd0);
		send_pixel(9'd0, 8'd0);
		send_pixel(9'd160, 8'd120);
		set_registers(16'd12345, 8'd64);
		send_pixel(9'd100, 8'd200);
		send_pixel(9'd300, 8'd10);

		// random phases across register settings
		for (int k = 0; k < 9; k++) begin
			set_registers(frames[k], brights[k]);
			random_pixels(158);
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
